// ===== hw/rtl/fbpa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the fixed block pool allocator.
// Depends on nothing; imported by fixed_block_pool_allocator.
package fbpa_pkg;

  // Pool geometry
  localparam int MAX_PAGES          = 64;
  localparam int MAX_SLOTS_PER_PAGE = 256;
  localparam int HEADER_BYTES       = 8;
  localparam int STACK_DEPTH        = MAX_PAGES * MAX_SLOTS_PER_PAGE;

  // Field and state widths
  localparam int PAGE_W   = 6;
  localparam int SLOT_W   = 8;
  localparam int HANDLE_W = PAGE_W + SLOT_W;
  localparam int COUNT_W  = 15;
  localparam int FREE_W   = 16;
  localparam int PCNT_W   = 7;
  localparam int SPP_W    = 9;
  localparam int ADDR_W   = 22;
  localparam int SIZE_W   = 16;
  localparam int BLOCK_W  = 17;
  localparam int ALIGN_W  = 4;

  // Sized limits
  localparam logic [COUNT_W-1:0] STACK_FULL = COUNT_W'(STACK_DEPTH);
  localparam logic [PCNT_W-1:0]  PAGE_LIMIT = PCNT_W'(MAX_PAGES);
  localparam logic [SPP_W-1:0]   SLOT_LIMIT = SPP_W'(MAX_SLOTS_PER_PAGE);
  localparam logic [SIZE_W-1:0]  HDR_SIZE   = SIZE_W'(HEADER_BYTES);
  localparam logic [ADDR_W-1:0]  HDR_ADDR   = ADDR_W'(HEADER_BYTES);

  // Reset values of the configuration and derived size registers
  localparam logic [SIZE_W-1:0]  DATA_SIZE_RST  = 16'd16;
  localparam logic [SIZE_W-1:0]  PAGE_SIZE_RST  = 16'd4096;
  localparam logic [ALIGN_W-1:0] ALIGN_RST      = 4'd3;
  localparam logic [BLOCK_W-1:0] BLOCK_BYTES_RST = 17'd16;
  localparam logic [SPP_W-1:0]   SLOTS_RST      = 9'd255;

  // Action codes
  typedef logic [1:0] action_t;
  localparam action_t ACT_ALLOC    = 2'd0;
  localparam action_t ACT_FREE     = 2'd1;
  localparam action_t ACT_FREE_ALL = 2'd2;

  // Error codes
  typedef logic [1:0] err_t;
  localparam err_t ERR_NONE       = 2'd0;
  localparam err_t ERR_NO_PAGES   = 2'd1;
  localparam err_t ERR_PAGE_SMALL = 2'd2;
  localparam err_t ERR_OVERFLOW   = 2'd3;

  // Configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_DATA_SIZE = 2'd0;
  localparam cfg_idx_t CFG_PAGE_SIZE = 2'd1;
  localparam cfg_idx_t CFG_ALIGN     = 2'd2;

endpackage

// ===== hw/rtl/fixed_block_pool_allocator.sv =====
`timescale 1ns / 1ps
// Fixed block pool allocator: LIFO free stack in a memory, page/slot bookkeeping,
// restoring divider for slots per page. Depends on fbpa_pkg.
// Accept to result: free, unknown and failed allocate actions are registered directly;
// allocate multiplies, then adds, after a memory read if it pops; free-all runs a
// 16-step restoring divider, one quotient bit per cycle, unless the page is below the
// header. One transaction at a time; the next is taken in the cycle after the result
// is registered, later while an older result still waits for out_ready.
// Reset (synchronous): registers to 16/4096/3, pool empty; stack memory is not cleared.
module fixed_block_pool_allocator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  fbpa_pkg::action_t                    in_action,
  input  logic [fbpa_pkg::PAGE_W-1:0]          in_free_page,
  input  logic [fbpa_pkg::SLOT_W-1:0]          in_free_slot,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_ok,
  output fbpa_pkg::err_t                       out_error_code,
  output logic [fbpa_pkg::PAGE_W-1:0]          out_block_page,
  output logic [fbpa_pkg::SLOT_W-1:0]          out_block_slot,
  output logic [fbpa_pkg::ADDR_W-1:0]          out_block_address,
  output logic [fbpa_pkg::PCNT_W-1:0]          out_pages_in_use,
  output logic [fbpa_pkg::COUNT_W-1:0]         out_total_blocks,
  output logic [fbpa_pkg::COUNT_W-1:0]         out_free_blocks,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  fbpa_pkg::cfg_idx_t                   cfg_index,
  input  logic [fbpa_pkg::SIZE_W-1:0]          cfg_data
);
  import fbpa_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_POP, S_MUL, S_ADD, S_DIV, S_OUT} state_t;

  state_t               state_r, state_nxt;
  logic [SIZE_W-1:0]    data_size_r, page_size_r;
  logic [ALIGN_W-1:0]   align_r;
  logic [COUNT_W-1:0]   stack_count_r, stack_count_nxt;
  logic [PCNT_W-1:0]    page_count_r, page_count_nxt;
  logic [SPP_W-1:0]     fresh_slot_r, fresh_slot_nxt;
  logic [COUNT_W-1:0]   block_total_r, block_total_nxt;
  logic [FREE_W-1:0]    block_free_r, block_free_nxt;
  logic [BLOCK_W-1:0]   block_bytes_r, block_bytes_nxt;
  logic [SPP_W-1:0]     slots_r, slots_nxt;
  logic [SIZE_W-1:0]    page_bytes_r, page_bytes_nxt;
  logic                 res_ok_r, res_ok_nxt;
  err_t                 res_err_r, res_err_nxt;
  logic [PAGE_W-1:0]    res_page_r, res_page_nxt;
  logic [SLOT_W-1:0]    res_slot_r, res_slot_nxt;
  logic [ADDR_W-1:0]    prod_page_r, prod_page_nxt;
  logic [ADDR_W-1:0]    prod_slot_r, prod_slot_nxt;
  logic [ADDR_W-1:0]    addr_r, addr_nxt;
  logic [BLOCK_W-1:0]   rem_r, rem_nxt;
  logic [SIZE_W-1:0]    quo_r, quo_nxt;
  logic [3:0]           div_cnt_r, div_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_ok_r, out_ok_nxt;
  err_t                 out_err_r, out_err_nxt;
  logic [PAGE_W-1:0]    out_page_r, out_page_nxt;
  logic [SLOT_W-1:0]    out_slot_r, out_slot_nxt;
  logic [ADDR_W-1:0]    out_addr_r, out_addr_nxt;
  logic [PCNT_W-1:0]    out_pages_r, out_pages_nxt;
  logic [COUNT_W-1:0]   out_total_r, out_total_nxt;
  logic [COUNT_W-1:0]   out_free_r, out_free_nxt;

  // free stack memory
  logic [HANDLE_W-1:0]  stack_mem [STACK_DEPTH];
  logic                 mem_we, mem_re;
  logic [HANDLE_W-1:0]  mem_waddr, mem_wdata, mem_raddr;
  logic [HANDLE_W-1:0]  mem_rdata_r;

  // datapath helpers
  logic [SIZE_W-1:0]    min_block, align_mask;
  logic [BLOCK_W-1:0]   rounded_block;
  logic [COUNT_W-1:0]   stack_dec;
  logic                 need_page;
  logic [PCNT_W-1:0]    page_inc;
  logic [FREE_W-1:0]    free_grown;
  logic [BLOCK_W-1:0]   div_shift, div_rem;
  logic                 div_ge;
  logic [SIZE_W-1:0]    div_quo;
  logic [PAGE_W+SIZE_W-1:0]  mul_page;
  logic [SLOT_W+BLOCK_W-1:0] mul_slot;

  // page of the newest opened page
  function automatic logic [PAGE_W-1:0] stack_free_page(input logic [PCNT_W-1:0] pcnt);
    logic [PCNT_W-1:0] last;
    last = pcnt - PCNT_W'(1);
    return last[PAGE_W-1:0];
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // block size: max(header, data size) rounded up to the alignment
  assign min_block     = (data_size_r > HDR_SIZE) ? data_size_r : HDR_SIZE;
  assign align_mask    = (SIZE_W'(1) << align_r) - SIZE_W'(1);
  assign rounded_block = ({1'b0, min_block} + {1'b0, align_mask}) & ~{1'b0, align_mask};

  assign stack_dec = stack_count_r - COUNT_W'(1);
  assign need_page = (page_count_r == '0) || (fresh_slot_r >= slots_r);
  assign page_inc  = page_count_r + PCNT_W'(1);
  assign free_grown = block_free_r + (need_page ? FREE_W'(slots_r) : '0);

  // one restoring division step
  assign div_shift = {rem_r[BLOCK_W-2:0], quo_r[SIZE_W-1]};
  assign div_ge    = (div_shift >= block_bytes_r);
  assign div_rem   = div_ge ? (div_shift - block_bytes_r) : div_shift;
  assign div_quo   = {quo_r[SIZE_W-2:0], div_ge};

  // address products
  assign mul_page = res_page_r * page_bytes_r;
  assign mul_slot = res_slot_r * block_bytes_r;

  // sequencer next state
  always_comb begin
    state_nxt       = state_r;
    stack_count_nxt = stack_count_r;
    page_count_nxt  = page_count_r;
    fresh_slot_nxt  = fresh_slot_r;
    block_total_nxt = block_total_r;
    block_free_nxt  = block_free_r;
    block_bytes_nxt = block_bytes_r;
    slots_nxt       = slots_r;
    page_bytes_nxt  = page_bytes_r;
    res_ok_nxt      = res_ok_r;
    res_err_nxt     = res_err_r;
    res_page_nxt    = res_page_r;
    res_slot_nxt    = res_slot_r;
    prod_page_nxt   = prod_page_r;
    prod_slot_nxt   = prod_slot_r;
    addr_nxt        = addr_r;
    rem_nxt         = rem_r;
    quo_nxt         = quo_r;
    div_cnt_nxt     = div_cnt_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_ok_nxt      = out_ok_r;
    out_err_nxt     = out_err_r;
    out_page_nxt    = out_page_r;
    out_slot_nxt    = out_slot_r;
    out_addr_nxt    = out_addr_r;
    out_pages_nxt   = out_pages_r;
    out_total_nxt   = out_total_r;
    out_free_nxt    = out_free_r;
    mem_we          = 1'b0;
    mem_waddr       = stack_count_r[HANDLE_W-1:0];
    mem_wdata       = {in_free_page, in_free_slot};
    mem_re          = 1'b0;
    mem_raddr       = stack_dec[HANDLE_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_ok_nxt   = 1'b0;
          res_err_nxt  = ERR_NONE;
          res_page_nxt = '0;
          res_slot_nxt = '0;
          addr_nxt     = '0;
          state_nxt    = S_OUT;
          case (in_action)
            ACT_ALLOC: begin
              if (stack_count_r != '0) begin
                // pop the most recently freed handle
                stack_count_nxt = stack_dec;
                mem_re          = 1'b1;
                if (block_free_r != '0) block_free_nxt = block_free_r - FREE_W'(1);
                res_ok_nxt      = 1'b1;
                state_nxt       = S_POP;
              end else if (slots_r == '0) begin
                res_err_nxt = ERR_PAGE_SMALL;
              end else if (need_page && (page_count_r >= PAGE_LIMIT)) begin
                res_err_nxt = ERR_NO_PAGES;
              end else begin
                // take the next unused slot, opening a page if needed
                if (need_page) begin
                  page_count_nxt  = page_inc;
                  block_total_nxt = block_total_r + COUNT_W'(slots_r);
                  fresh_slot_nxt  = SPP_W'(1);
                  res_page_nxt    = page_count_r[PAGE_W-1:0];
                  res_slot_nxt    = '0;
                end else begin
                  fresh_slot_nxt  = fresh_slot_r + SPP_W'(1);
                  res_page_nxt    = stack_free_page(page_count_r);
                  res_slot_nxt    = fresh_slot_r[SLOT_W-1:0];
                end
                block_free_nxt = (free_grown != '0) ? free_grown - FREE_W'(1) : free_grown;
                res_ok_nxt     = 1'b1;
                state_nxt      = S_MUL;
              end
            end
            ACT_FREE: begin
              if (stack_count_r >= STACK_FULL) begin
                res_err_nxt = ERR_OVERFLOW;
              end else begin
                // push the handle
                mem_we          = 1'b1;
                stack_count_nxt = stack_count_r + COUNT_W'(1);
                block_free_nxt  = block_free_r + FREE_W'(1);
                res_ok_nxt      = 1'b1;
              end
            end
            ACT_FREE_ALL: begin
              // clear the pool and latch new sizes
              stack_count_nxt = '0;
              page_count_nxt  = '0;
              fresh_slot_nxt  = '0;
              block_total_nxt = '0;
              block_free_nxt  = '0;
              block_bytes_nxt = rounded_block;
              page_bytes_nxt  = page_size_r;
              if (page_size_r < HDR_SIZE) begin
                slots_nxt   = '0;
                res_err_nxt = ERR_PAGE_SMALL;
              end else begin
                rem_nxt     = '0;
                quo_nxt     = page_size_r - HDR_SIZE;
                div_cnt_nxt = '0;
                state_nxt   = S_DIV;
              end
            end
            default: begin
              // unknown action: report nothing done
            end
          endcase
        end
      end
      S_POP: begin
        res_page_nxt = mem_rdata_r[HANDLE_W-1:SLOT_W];
        res_slot_nxt = mem_rdata_r[SLOT_W-1:0];
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        prod_page_nxt = mul_page[ADDR_W-1:0];
        prod_slot_nxt = mul_slot[ADDR_W-1:0];
        state_nxt     = S_ADD;
      end
      S_ADD: begin
        addr_nxt  = prod_page_r + prod_slot_r + HDR_ADDR;
        state_nxt = S_OUT;
      end
      S_DIV: begin
        rem_nxt     = div_rem;
        quo_nxt     = div_quo;
        div_cnt_nxt = div_cnt_r + 4'd1;
        if (div_cnt_r == 4'hF) begin
          // saturate the quotient to the slot table bound
          slots_nxt   = (div_quo > SIZE_W'(SLOT_LIMIT)) ? SLOT_LIMIT : div_quo[SPP_W-1:0];
          res_ok_nxt  = (div_quo != '0);
          res_err_nxt = (div_quo != '0) ? ERR_NONE : ERR_PAGE_SMALL;
          state_nxt   = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_err_nxt   = res_err_r;
          out_page_nxt  = res_page_r;
          out_slot_nxt  = res_slot_r;
          out_addr_nxt  = addr_r;
          out_pages_nxt = page_count_r;
          out_total_nxt = block_total_r;
          out_free_nxt  = block_free_r[COUNT_W-1:0];
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state, configuration and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      data_size_r   <= DATA_SIZE_RST;
      page_size_r   <= PAGE_SIZE_RST;
      align_r       <= ALIGN_RST;
      stack_count_r <= '0;
      page_count_r  <= '0;
      fresh_slot_r  <= '0;
      block_total_r <= '0;
      block_free_r  <= '0;
      block_bytes_r <= BLOCK_BYTES_RST;
      slots_r       <= SLOTS_RST;
      page_bytes_r  <= PAGE_SIZE_RST;
      div_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      stack_count_r <= stack_count_nxt;
      page_count_r  <= page_count_nxt;
      fresh_slot_r  <= fresh_slot_nxt;
      block_total_r <= block_total_nxt;
      block_free_r  <= block_free_nxt;
      block_bytes_r <= block_bytes_nxt;
      slots_r       <= slots_nxt;
      page_bytes_r  <= page_bytes_nxt;
      div_cnt_r     <= div_cnt_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_DATA_SIZE: data_size_r <= cfg_data;
          CFG_PAGE_SIZE: page_size_r <= cfg_data;
          CFG_ALIGN:     align_r     <= cfg_data[ALIGN_W-1:0];
          default: ;
        endcase
      end
    end
    res_ok_r    <= res_ok_nxt;
    res_err_r   <= res_err_nxt;
    res_page_r  <= res_page_nxt;
    res_slot_r  <= res_slot_nxt;
    prod_page_r <= prod_page_nxt;
    prod_slot_r <= prod_slot_nxt;
    addr_r      <= addr_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    out_ok_r    <= out_ok_nxt;
    out_err_r   <= out_err_nxt;
    out_page_r  <= out_page_nxt;
    out_slot_r  <= out_slot_nxt;
    out_addr_r  <= out_addr_nxt;
    out_pages_r <= out_pages_nxt;
    out_total_r <= out_total_nxt;
    out_free_r  <= out_free_nxt;
  end

  // free stack: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) stack_mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_r <= stack_mem[mem_raddr];
  end

  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_error_code    = out_err_r;
  assign out_block_page    = out_page_r;
  assign out_block_slot    = out_slot_r;
  assign out_block_address = out_addr_r;
  assign out_pages_in_use  = out_pages_r;
  assign out_total_blocks  = out_total_r;
  assign out_free_blocks   = out_free_r;

endmodule
